// File: rtl/scdp_pkg.sv
`default_nettype none

package scdp_pkg;

  // Block sizing
  localparam int MAX_WIDTH    = 1024;
  localparam int COST_BITS    = 24;
  localparam int HEIGHT_LIMIT = 1024;

  // Field and register widths
  localparam int ENERGY_BITS = 12;
  localparam int DIM_BITS    = 11;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(HEIGHT_LIMIT);
  localparam int CNT_BITS    = (DIM_BITS > COL_BITS + 1) ? DIM_BITS : COL_BITS + 1;

  // Stream bus widths, padded to whole bytes
  localparam int IN_TDATA_BITS  = ((ENERGY_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((COST_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1024);

  typedef logic [COST_BITS-1:0] cost_t;

  typedef struct packed {
    logic  frame_last;
    cost_t seam_cost;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/scdp_line_store.sv
`default_nettype none

// Previous-row cost store: one write port, one registered read port.
// A read of the address being written in the same cycle returns the new data.
module scdp_line_store (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [scdp_pkg::COL_BITS-1:0] wr_addr,
  input  wire scdp_pkg::cost_t               wr_data,
  input  wire logic                          rd_en,
  input  wire logic [scdp_pkg::COL_BITS-1:0] rd_addr,
  output scdp_pkg::cost_t                    rd_data
);
  import scdp_pkg::*;

  cost_t mem [MAX_WIDTH];
  cost_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/scdp_out_buf.sv
`default_nettype none

// Two-entry result buffer: keeps the input side moving while the
// receiver stalls, until both entries are full.
module scdp_out_buf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire scdp_pkg::out_item_t push_item,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output scdp_pkg::out_item_t      pop_item
);
  import scdp_pkg::*;

  out_item_t  entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("out buffer count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("out buffer pointers disagree with count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("out buffer count did not advance on push");

endmodule

`default_nettype wire

// File: rtl/seam_cost_dynamic_program.sv
// Vertical seam cost matrix, streaming.
// in_*  : energy beats in raster order, one pixel per beat (tdata[11:0] energy).
// out_* : one cost beat per input beat, same order; tdata[23:0] cumulative
//         seam cost (saturating), tlast marks the last pixel of the frame.
// cfg_* : write-only registers, index 0 image_width, index 1 image_height.
//         Write only between beats; a change applies from the next beat.
// Results: the cost of a beat is registered into the result buffer at the
// edge that accepts it. Throughput: one beat per cycle while out_tready
// stays high; the line store does one write and one registered read per
// beat, the read fetching column c+2 ahead of use so the three-neighbor
// minimum needs only registered values.
// Reset (rst_n low, synchronous): row/column back to zero, registers back
// to 1024 x 1024, result buffer emptied. The line store is not cleared;
// row 0 ignores what it returns.
// Stall: results go through a two-entry buffer, so in_tready stays high
//         while the receiver holds off, until both entries are full; then it drops.
`default_nettype none

module seam_cost_dynamic_program (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [scdp_pkg::IN_TDATA_BITS-1:0]  in_tdata,   // [11:0] energy_value
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [scdp_pkg::OUT_TDATA_BITS-1:0] out_tdata,  // [23:0] seam_cost
  output logic                                     out_tlast,  // frame_last
  input  wire logic                                cfg_wr_en,
  input  wire logic [scdp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [scdp_pkg::DIM_BITS-1:0]       cfg_wdata
);
  import scdp_pkg::*;

  // config registers
  logic [DIM_BITS-1:0] width_cfg_r;
  logic [DIM_BITS-1:0] height_cfg_r;

  // position and previous-row window
  logic [COL_BITS-1:0] col_r;
  logic [ROW_BITS-1:0] row_r;
  cost_t               up_r;     // previous row, column c
  cost_t               left_r;   // previous row, column c-1
  cost_t               col0_r;   // this row's cost at column 0
  cost_t               right_rd; // previous row, column c+1 (line store output)

  logic [CNT_BITS-1:0] w_used;
  logic [CNT_BITS-1:0] h_used;
  logic [CNT_BITS-1:0] c_ext;
  logic                row_end;
  logic                frame_end;
  logic                accept;

  logic [ENERGY_BITS-1:0] energy;
  cost_t                  best_lu;
  cost_t                  best;
  logic [COST_BITS:0]     sum;
  cost_t                  cost;

  logic [COL_BITS-1:0] rd_addr;
  out_item_t           res_item;
  out_item_t           out_item;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= DIM_RESET;
      height_cfg_r <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_cfg_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_cfg_r <= cfg_wdata;
      endcase
    end
  end

  // clamp to the supported range: width 2..MAX_WIDTH, height 1..HEIGHT_LIMIT
  always_comb begin
    w_used = CNT_BITS'(width_cfg_r);
    if (w_used < CNT_BITS'(2)) begin
      w_used = CNT_BITS'(2);
    end else if (w_used > CNT_BITS'(MAX_WIDTH)) begin
      w_used = CNT_BITS'(MAX_WIDTH);
    end
    h_used = CNT_BITS'(height_cfg_r);
    if (h_used == '0) begin
      h_used = CNT_BITS'(1);
    end else if (h_used > CNT_BITS'(HEIGHT_LIMIT)) begin
      h_used = CNT_BITS'(HEIGHT_LIMIT);
    end
  end

  assign c_ext     = CNT_BITS'(col_r);
  assign row_end   = (c_ext + CNT_BITS'(1)) >= w_used;
  assign frame_end = row_end && ((CNT_BITS'(row_r) + CNT_BITS'(1)) >= h_used);
  assign accept    = in_tvalid && in_tready;

  // ------------------------------------------------------------- cost path
  assign energy = in_tdata[ENERGY_BITS-1:0];

  // left neighbor exists past column 0, right one unless this is the row end
  always_comb begin
    best_lu = up_r;
    if ((col_r != '0) && (left_r < up_r)) begin
      best_lu = left_r;
    end
    best = best_lu;
    if (!row_end && (right_rd < best_lu)) begin
      best = right_rd;
    end
  end

  assign sum = {1'b0, best} + (COST_BITS + 1)'(energy);

  always_comb begin
    if (row_r == '0) begin
      cost = COST_BITS'(energy);
    end else if (sum[COST_BITS]) begin
      cost = '1;
    end else begin
      cost = sum[COST_BITS-1:0];
    end
  end

  // next row starts from column 0/1 of this row; otherwise fetch c+2
  assign rd_addr = row_end ? COL_BITS'(1) : COL_BITS'(c_ext + CNT_BITS'(2));

  scdp_line_store u_line_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (cost),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (right_rd)
  );

  // ------------------------------------------------------ position / window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_r <= col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (col_r == '0) begin
        col0_r <= cost;
      end
      if (row_end) begin
        up_r   <= col0_r;
        left_r <= '0;
      end else begin
        up_r   <= right_rd;
        left_r <= up_r;
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign res_item.frame_last = frame_end;
  assign res_item.seam_cost  = cost;

  scdp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_item  (res_item),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_item   (out_item)
  );

  assign out_tdata = OUT_TDATA_BITS'(out_item.seam_cost);
  assign out_tlast = out_item.frame_last;

  // ------------------------------------------------------------ assertions
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && row_end) |=> (col_r == '0))
    else $error("column did not wrap at row end");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !row_end) |=> (col_r == $past(col_r) + COL_BITS'(1)))
    else $error("column did not advance");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |=> (row_r == '0))
    else $error("row did not wrap at frame end");

  a_last_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_end) |-> row_end)
    else $error("frame end outside a row end");

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import scdp_pkg::*;

  localparam int          RAND_BEATS  = 800;
  localparam int          QUIET_BEATS = 120;     // tail of the run with no idling
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          TAIL_CYCLES = 8;       // margin after the drain
  localparam longint unsigned COST_MAX = (64'd1 << COST_BITS) - 1;

  typedef enum logic { STEP_BEAT, STEP_WRITE } step_kind_t;

  // One row of the directed table: either a register write or an energy beat.
  // A beat with typed set carries its expected result, which replaces the
  // predictor's; all others are checked against the predictor.
  typedef struct {
    step_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [DIM_BITS-1:0]       value;
    logic [ENERGY_BITS-1:0]    energy;
    bit                        typed;
    cost_t                     cost;
    logic                      last;
  } step_t;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata   = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      out_tlast;
  logic                      cfg_wr_en  = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index  = '0;
  logic [DIM_BITS-1:0]       cfg_wdata  = '0;

  // Typed expectation riding along with the beat on the bus
  bit                        tag_typed  = 1'b0;
  cost_t                     tag_cost   = '0;
  logic                      tag_last   = 1'b0;

  // Predictor state: registers, position and line store of previous-row costs
  logic [DIM_BITS-1:0]       width_reg  = DIM_RESET;
  logic [DIM_BITS-1:0]       height_reg = DIM_RESET;
  int unsigned               col_pos    = 0;
  int unsigned               row_pos    = 0;
  longint unsigned           left_cost  = 0;
  longint unsigned           line_costs [MAX_WIDTH];
  bit                        line_written [MAX_WIDTH];

  out_item_t                 cost_expect_q [$];
  step_t                     steps [$];
  int                        beats_in   = 0;     // accepted on in_*
  int                        beats_out  = 0;     // accepted on out_*
  int                        mismatches = 0;
  int                        cycle_count = 0;
  bit                        quiet_tail = 1'b0;
  int                        stall_left = 0;

  seam_cost_dynamic_program DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [11:0] energy_value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [23:0] seam_cost
    .out_tlast  (out_tlast),   // frame_last
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_costs[i]   = 0;
      line_written[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH out beat %0d: %s", beats_out, msg);
    mismatches++;
  endtask

  // Width 0/1 acts as 2, anything past the line store as its size
  function automatic int unsigned used_width();
    int unsigned w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // Height 0 acts as 1, capped at the row counter's range
  function automatic int unsigned used_height();
    int unsigned h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  // Cost of one pixel: energy, plus past row 0 the cheapest of three cells above it,
  // then advance column/row. Updates the line store in place; the c-1 entry
  // is kept in left_cost since it has already been overwritten.
  task automatic predict_seam_cost(input logic [ENERGY_BITS-1:0] energy,
                                   output out_item_t item);
    int unsigned     w;
    int unsigned     h;
    int unsigned     c;
    bit              row_end;
    bit              frame_end;
    longint unsigned up;
    longint unsigned best;
    longint unsigned sum;
    w         = used_width();
    h         = used_height();
    c         = col_pos;
    row_end   = (c + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    up = line_costs[c];
    if (row_pos == 0) begin
      sum = energy;
    end else begin
      best = up;
      if (c > 0 && left_cost < best) best = left_cost;
      if (c + 1 < w && c + 1 < MAX_WIDTH && line_costs[c+1] < best) best = line_costs[c+1];
      sum = energy + best;
    end
    if (sum > COST_MAX) sum = COST_MAX;
    left_cost       = up;
    line_costs[c]   = sum;
    line_written[c] = 1'b1;
    if (row_end) begin
      col_pos   = 0;
      left_cost = 0;
      row_pos   = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
    item.seam_cost  = cost_t'(sum);
    item.frame_last = frame_end;
  endtask

  // Monitor: everything sampled at the rising edge, pre-edge values.
  // Register writes and input beats feed the predictor; output beats are
  // checked against the oldest expectation.
  always @(posedge clk) begin : monitor
    out_item_t pred;
    out_item_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_IMAGE_WIDTH)       width_reg  = cfg_wdata;
        else if (cfg_index == CFG_IMAGE_HEIGHT) height_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        predict_seam_cost(in_tdata[ENERGY_BITS-1:0], pred);
        if (tag_typed) begin
          pred.seam_cost  = tag_cost;
          pred.frame_last = tag_last;
        end
        cost_expect_q.push_back(pred);
      end
      if (out_tvalid && out_tready) begin
        if (cost_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat cost %0h last %0b",
                                    out_tdata[COST_BITS-1:0], out_tlast));
        end else begin
          want = cost_expect_q.pop_front();
          if (out_tdata[COST_BITS-1:0] !== want.seam_cost)
            report_mismatch($sformatf("seam_cost got %0h want %0h",
                                      out_tdata[COST_BITS-1:0], want.seam_cost));
          if (out_tlast !== want.frame_last)
            report_mismatch($sformatf("frame_last got %0b want %0b",
                                      out_tlast, want.frame_last));
        end
        beats_out++;
      end
    end
  end

  // Receiver back-pressure: random stall bursts, none at the tail
  always @(posedge clk) begin
    if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 10);
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d of %0d beats out", cycle_count, beats_out,
               beats_in);
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold input off until every result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (beats_out < beats_in);
  endtask

  // Registers only change with the block idle
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [DIM_BITS-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_energy(input logic [ENERGY_BITS-1:0] energy, input bit typed,
                             input cost_t cost, input logic last);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_BITS'(energy);
    tag_typed <= typed;
    tag_cost  <= cost;
    tag_last  <= last;
    do @(posedge clk); while (!in_tready);
    beats_in++;
  endtask

  task automatic add_step(input step_kind_t kind, input logic [CFG_IDX_BITS-1:0] idx,
                          input logic [DIM_BITS-1:0] value,
                          input logic [ENERGY_BITS-1:0] energy,
                          input bit typed, input cost_t cost, input logic last);
    step_t s;
    s.kind   = kind;
    s.idx    = idx;
    s.value  = value;
    s.energy = energy;
    s.typed  = typed;
    s.cost   = cost;
    s.last   = last;
    steps.push_back(s);
  endtask

  function automatic logic [ENERGY_BITS-1:0] random_energy();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return ENERGY_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned          w;
    int unsigned          h;
    int unsigned          prefix;
    int unsigned          rem;
    int unsigned          n;
    int                   rand_beats;
    logic [DIM_BITS-1:0]  val;

    // Directed table. Right after reset the frame is 1024 x 1024, so row 0
    // costs are just the energy.
    add_step(STEP_BEAT,  '0, '0, 12'h000, 1, 24'h000000, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'hFFF, 1, 24'h000FFF, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'h001, 1, 24'h000001, 1'b0);
    // oversize width and height clamp to the maximum; still row 0
    add_step(STEP_WRITE, CFG_IMAGE_WIDTH,  11'd2047, '0, 0, '0, 1'b0);
    add_step(STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd2047, '0, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'hAAA, 1, 24'h000AAA, 1'b0);
    // width 1 acts as 2: column already past the end, so this beat ends row 0
    add_step(STEP_WRITE, CFG_IMAGE_WIDTH,  11'd1, '0, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'h555, 1, 24'h000555, 1'b0);
    // height 0 acts as 1: the current row (row 1) becomes the last of the frame
    add_step(STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd0, '0, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'd10,  0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'd20,  0, '0, 1'b0);
    // minimal 2 x 3 frame, edge columns on both sides
    add_step(STEP_WRITE, CFG_IMAGE_WIDTH,  11'd0, '0, 0, '0, 1'b0);
    add_step(STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd3, '0, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'hFFF, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'h000, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'h000, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'hFFF, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'hFFF, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'hFFF, 0, '0, 1'b0);
    // 5 x 2 frame, width shrunk to 3 mid row 1 so the column past it ends the frame
    add_step(STEP_WRITE, CFG_IMAGE_WIDTH,  11'd5, '0, 0, '0, 1'b0);
    add_step(STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd2, '0, 0, '0, 1'b0);
    repeat (5) add_step(STEP_BEAT, '0, '0, 12'hFFF, 1, 24'h000FFF, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'd100, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'd200, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'd300, 0, '0, 1'b0);
    add_step(STEP_WRITE, CFG_IMAGE_WIDTH,  11'd3, '0, 0, '0, 1'b0);
    add_step(STEP_BEAT,  '0, '0, 12'd400, 0, '0, 1'b0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].kind == STEP_WRITE)
        write_register(steps[i].idx, steps[i].value);
      else
        send_energy(steps[i].energy, steps[i].typed, steps[i].cost, steps[i].last);
    end

    // Random phases. Each register write waits for the pipe to empty, which
    // also gives the sender-paused-until-drained case. The predictor is
    // settled there, so its position can steer the next phase.
    rand_beats = 0;
    while (rand_beats < RAND_BEATS) begin
      if ($urandom_range(0, 2) != 0) begin
        drain_results();
        case ($urandom_range(0, 19))
          0, 1, 2:            val = DIM_BITS'($urandom_range(0, 2047));
          3, 4, 5, 6, 7:      val = DIM_BITS'($urandom_range(9, 40));
          default:            val = DIM_BITS'($urandom_range(0, 8));
        endcase
        // Mid-frame, never widen past the columns the line store has seen
        if (row_pos != 0) begin
          prefix = 0;
          while (prefix < MAX_WIDTH && line_written[prefix]) prefix++;
          w = (val < 2) ? 2 : ((val > MAX_WIDTH) ? MAX_WIDTH : val);
          if (w > prefix) val = DIM_BITS'($urandom_range(2, prefix));
        end
        write_register(CFG_IMAGE_WIDTH, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 19))
          0, 1, 2:            val = DIM_BITS'($urandom_range(0, 2047));
          3, 4, 5, 6, 7, 8:   val = DIM_BITS'($urandom_range(5, 20));
          default:            val = DIM_BITS'($urandom_range(0, 4));
        endcase
        write_register(CFG_IMAGE_HEIGHT, val);
      end

      // Often run to the end of the current frame so full frames wrap around
      w   = used_width();
      h   = used_height();
      rem = (col_pos + 1 >= w) ? 1 : w - col_pos;
      if (row_pos + 1 < h) rem += (h - 1 - row_pos) * w;
      if ($urandom_range(0, 1) == 0 && rem <= 150) n = rem;
      else n = $urandom_range(1, 40);

      repeat (n) begin
        send_energy(random_energy(), 1'b0, '0, 1'b0);
        rand_beats++;
        quiet_tail = (rand_beats >= RAND_BEATS - QUIET_BEATS);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cost_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expected beats never came", cost_expect_q.size()));

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
